// File: sv/sxalu_pkg.sv
// Package for the six-operation integer ALU: codes, sequencer states and unit constants.
package sxalu_pkg;

  // Operation codes carried on the func input.
  localparam logic [2:0] FUNC_ADD = 3'd0;
  localparam logic [2:0] FUNC_SUB = 3'd1;
  localparam logic [2:0] FUNC_MUL = 3'd2;
  localparam logic [2:0] FUNC_DIV = 3'd3;
  localparam logic [2:0] FUNC_REM = 3'd4;
  localparam logic [2:0] FUNC_POW = 3'd5;

  // Status codes carried on the status output.
  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_DIV_ZERO = 2'd1;
  localparam logic [1:0] STAT_NEG_EXP  = 2'd2;

  // The multiplier consumes one digit of this many bits per cycle.
  localparam int unsigned DIGIT_W = 8;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ADDSUB,
    ST_MUL,
    ST_POW,
    ST_NEGA,
    ST_NEGB,
    ST_DIV,
    ST_FIX,
    ST_DONE
  } state_e;

endpackage

// File: sv/six_op_integer_alu.sv
// Top level of the six-operation integer ALU: handshakes, sequencer and working registers.
// Add and subtract run through ST_ADDSUB; multiply walks NDIG = ceil(DATA_WIDTH/8)
// multiplier digits, one 8-bit digit per cycle; divide and remainder run one restoring
// step per cycle; power repeats the multiply, at most two multiplies per exponent bit.
// Errors and unused codes go straight to the done state. A new word is taken only in the idle
// state, once the previous result has been registered; rst_ni clears the sequencer and output valid.
module six_op_integer_alu
  import sxalu_pkg::*;
#(
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic signed [DATA_WIDTH-1:0] op_a_i,
  input  logic signed [DATA_WIDTH-1:0] op_b_i,
  input  logic        [2:0]            func_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic signed [DATA_WIDTH-1:0] result_o,
  output logic        [1:0]            status_o
);

  localparam int unsigned NDIG = (DATA_WIDTH + DIGIT_W - 1) / DIGIT_W;
  localparam int unsigned SH_W = NDIG * DIGIT_W;
  localparam int unsigned CW   = $clog2(DATA_WIDTH);
  localparam logic [CW-1:0] DIV_LAST = CW'(DATA_WIDTH - 1);
  localparam logic [CW-1:0] MUL_LAST = CW'(NDIG - 1);

  state_e state_q, state_d;
  logic                  out_valid_q, out_valid_d;
  logic [DATA_WIDTH-1:0] res_q, res_d;
  logic [1:0]            stat_q, stat_d;
  logic [1:0]            st_q, st_d;
  logic [2:0]            func_q, func_d;
  logic [DATA_WIDTH-1:0] r_q, r_d;
  logic [DATA_WIDTH-1:0] s_q, s_d;
  logic [DATA_WIDTH-1:0] e_q, e_d;
  logic [DATA_WIDTH-1:0] m_q, m_d;
  logic [DATA_WIDTH-1:0] p_q, p_d;
  logic [SH_W-1:0]       sh_q, sh_d;
  logic [CW-1:0]         cnt_q, cnt_d;
  logic                  pow_q, pow_d;
  logic                  dest_s_q, dest_s_d;
  logic                  sa_q, sa_d;
  logic                  sb_q, sb_d;

  logic                  in_acc;
  logic                  out_free;
  logic                  b_zero;
  logic [DATA_WIDTH-1:0] add_x, add_y, add_sum, mac_res;
  logic                  add_sub, add_carry;
  logic [DATA_WIDTH-1:0] div_shift;
  logic [DATA_WIDTH-1:0] fix_val;
  logic                  fix_neg;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign b_zero      = (op_b_i == '0);
  assign out_valid_o = out_valid_q;
  assign result_o    = res_q;
  assign status_o    = stat_q;

  // Restoring divide: remainder shifted left with the next dividend bit.
  assign div_shift = {r_q[DATA_WIDTH-2:0], s_q[DATA_WIDTH-1]};

  // Final sign fix: quotient takes the sign of the operand signs' difference,
  // remainder the sign of the dividend.
  assign fix_val = (func_q == FUNC_DIV) ? s_q : r_q;
  assign fix_neg = (func_q == FUNC_DIV) ? (sa_q ^ sb_q) : sa_q;

  // Operand selection for the shared adder.
  always_comb begin
    add_x   = '0;
    add_y   = '0;
    add_sub = 1'b1;
    case (state_q)
      ST_ADDSUB: begin
        add_x   = r_q;
        add_y   = e_q;
        add_sub = (func_q == FUNC_SUB);
      end
      ST_NEGA: add_y = s_q;
      ST_NEGB: add_y = e_q;
      ST_DIV: begin
        add_x = div_shift;
        add_y = e_q;
      end
      ST_FIX: add_y = fix_val;
      default: add_y = '0;
    endcase
  end

  sxalu_unit #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_unit (
    .add_x_i    (add_x),
    .add_y_i    (add_y),
    .add_sub_i  (add_sub),
    .add_sum_o  (add_sum),
    .add_carry_o(add_carry),
    .mac_acc_i  (p_q),
    .mac_m_i    (m_q),
    .mac_digit_i(sh_q[SH_W-1 -: DIGIT_W]),
    .mac_o      (mac_res)
  );

  // Next state of the sequencer.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          case (func_i)
            FUNC_ADD, FUNC_SUB: state_d = ST_ADDSUB;
            FUNC_MUL:           state_d = ST_MUL;
            FUNC_DIV, FUNC_REM: state_d = b_zero ? ST_DONE : ST_NEGA;
            FUNC_POW:           state_d = op_b_i[DATA_WIDTH-1] ? ST_DONE : ST_POW;
            default:            state_d = ST_DONE;
          endcase
        end
      end
      ST_ADDSUB: state_d = ST_DONE;
      ST_MUL: begin
        if (cnt_q == MUL_LAST) begin
          state_d = pow_q ? ST_POW : ST_DONE;
        end
      end
      ST_POW:  state_d = (e_q == '0) ? ST_DONE : ST_MUL;
      ST_NEGA: state_d = ST_NEGB;
      ST_NEGB: state_d = ST_DIV;
      ST_DIV: begin
        if (cnt_q == DIV_LAST) begin
          state_d = ST_FIX;
        end
      end
      ST_FIX: state_d = ST_DONE;
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Working registers and the output word.
  always_comb begin
    out_valid_d = out_valid_q;
    res_d       = res_q;
    stat_d      = stat_q;
    st_d        = st_q;
    func_d      = func_q;
    r_d         = r_q;
    s_d         = s_q;
    e_d         = e_q;
    m_d         = m_q;
    p_d         = p_q;
    sh_d        = sh_q;
    cnt_d       = cnt_q;
    pow_d       = pow_q;
    dest_s_d    = dest_s_q;
    sa_d        = sa_q;
    sb_d        = sb_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          func_d = func_i;
          st_d   = STAT_OK;
          r_d    = '0;
          s_d    = op_a_i;
          e_d    = op_b_i;
          sa_d   = op_a_i[DATA_WIDTH-1];
          sb_d   = op_b_i[DATA_WIDTH-1];
          m_d    = op_a_i;
          sh_d   = SH_W'(op_b_i);
          p_d    = '0;
          cnt_d  = '0;
          pow_d  = 1'b0;
          case (func_i)
            FUNC_ADD, FUNC_SUB: r_d = op_a_i;
            FUNC_DIV, FUNC_REM: begin
              if (b_zero) begin
                st_d = STAT_DIV_ZERO;
              end
            end
            FUNC_POW: begin
              pow_d = 1'b1;
              r_d   = DATA_WIDTH'(1);
              if (op_b_i[DATA_WIDTH-1]) begin
                st_d = STAT_NEG_EXP;
                r_d  = '0;
              end
            end
            default: r_d = '0;
          endcase
        end
      end
      ST_ADDSUB: r_d = add_sum;
      ST_MUL: begin
        p_d   = mac_res;
        sh_d  = sh_q << DIGIT_W;
        cnt_d = cnt_q + CW'(1);
        if (cnt_q == MUL_LAST) begin
          if (!pow_q) begin
            r_d = mac_res;
          end else if (dest_s_q) begin
            // Square done: drop the exponent bit just used.
            s_d = mac_res;
            e_d = e_q >> 1;
          end else begin
            // Odd exponent: the accumulator took the product with the base, clear the low bit.
            r_d = mac_res;
            e_d = {e_q[DATA_WIDTH-1:1], 1'b0};
          end
        end
      end
      ST_POW: begin
        p_d   = '0;
        cnt_d = '0;
        sh_d  = SH_W'(s_q);
        if (e_q[0]) begin
          m_d      = r_q;
          dest_s_d = 1'b0;
        end else begin
          m_d      = s_q;
          dest_s_d = 1'b1;
        end
      end
      ST_NEGA: begin
        if (sa_q) begin
          s_d = add_sum;
        end
      end
      ST_NEGB: begin
        if (sb_q) begin
          e_d = add_sum;
        end
        r_d   = '0;
        cnt_d = '0;
      end
      ST_DIV: begin
        r_d   = add_carry ? add_sum : div_shift;
        s_d   = {s_q[DATA_WIDTH-2:0], add_carry};
        cnt_d = cnt_q + CW'(1);
      end
      ST_FIX: r_d = fix_neg ? add_sum : fix_val;
      ST_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          res_d       = r_q;
          stat_d      = st_q;
        end
      end
      default: r_d = r_q;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    res_q    <= res_d;
    stat_q   <= stat_d;
    st_q     <= st_d;
    func_q   <= func_d;
    r_q      <= r_d;
    s_q      <= s_d;
    e_q      <= e_d;
    m_q      <= m_d;
    p_q      <= p_d;
    sh_q     <= sh_d;
    cnt_q    <= cnt_d;
    pow_q    <= pow_d;
    dest_s_q <= dest_s_d;
    sa_q     <= sa_d;
    sb_q     <= sb_d;
  end

endmodule

// File: sv/sxalu_unit.sv
// Shared arithmetic unit: one adder/subtractor and one digit multiply-accumulate step.
module sxalu_unit
  import sxalu_pkg::*;
#(
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic [DATA_WIDTH-1:0] add_x_i,
  input  logic [DATA_WIDTH-1:0] add_y_i,
  input  logic                  add_sub_i,
  output logic [DATA_WIDTH-1:0] add_sum_o,
  output logic                  add_carry_o,
  input  logic [DATA_WIDTH-1:0] mac_acc_i,
  input  logic [DATA_WIDTH-1:0] mac_m_i,
  input  logic [DIGIT_W-1:0]    mac_digit_i,
  output logic [DATA_WIDTH-1:0] mac_o
);

  logic [DATA_WIDTH:0]           add_full;
  logic [DATA_WIDTH-1:0]         add_y_eff;
  logic [DATA_WIDTH+DIGIT_W-1:0] acc_sh;
  logic [DATA_WIDTH+DIGIT_W-1:0] prod;

  // Subtraction is the add of the inverted operand plus one; the carry out means no borrow.
  assign add_y_eff   = add_sub_i ? ~add_y_i : add_y_i;
  assign add_full    = {1'b0, add_x_i} + {1'b0, add_y_eff} + (DATA_WIDTH+1)'(add_sub_i);
  assign add_sum_o   = add_full[DATA_WIDTH-1:0];
  assign add_carry_o = add_full[DATA_WIDTH];

  // Horner step over the multiplier digits, most significant first, kept modulo the word.
  assign acc_sh = {mac_acc_i, {DIGIT_W{1'b0}}};
  assign prod   = {{DIGIT_W{1'b0}}, mac_m_i} * {{DATA_WIDTH{1'b0}}, mac_digit_i};
  assign mac_o  = acc_sh[DATA_WIDTH-1:0] + prod[DATA_WIDTH-1:0];

endmodule
